[hw/rtl/mtsl_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the median block.
package mtsl_pkg;

  localparam int unsigned DepthA = 256;
  localparam int unsigned DepthB = 256;
  localparam int unsigned AddrAW = $clog2(DepthA);
  localparam int unsigned AddrBW = $clog2(DepthB);
  localparam int unsigned CntAW  = $clog2(DepthA + 1);
  localparam int unsigned CntBW  = $clog2(DepthB + 1);
  localparam int unsigned IdxW   = $clog2(DepthA + DepthB + 1) + 1;
  localparam int unsigned ValW   = 32;
  localparam int unsigned ResW   = ValW + 1;

  localparam logic [1:0] FuncAppendA = 2'd0;
  localparam logic [1:0] FuncAppendB = 2'd1;
  localparam logic [1:0] FuncMedian  = 2'd2;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic capture;
    logic init;
    logic issue;
    logic step;
    logic keep_first;
    logic finish;
    logic finish_empty;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic term;
    logic need_second;
  } sts_t;

endpackage

[hw/rtl/mtsl_ctrl.sv]
// Controller state machine: decodes transactions and sequences the selection passes.
module mtsl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        func_i,
  input  mtsl_pkg::sts_t    sts_i,
  output mtsl_pkg::cmd_t    cmd_o,
  output logic              busy
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StInit  = 2'd1;
  localparam logic [1:0] StIssue = 2'd2;
  localparam logic [1:0] StEval  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          case (func_i)
            mtsl_pkg::FuncAppendA: cmd_o.load_a = 1'b1;
            mtsl_pkg::FuncAppendB: cmd_o.load_b = 1'b1;
            mtsl_pkg::FuncMedian: begin
              cmd_o.capture = 1'b1;
              state_d       = StInit;
            end
            default: ;
          endcase
        end
      end
      StInit: begin
        if (sts_i.empty) begin
          cmd_o.finish_empty = 1'b1;
          state_d            = StIdle;
        end else begin
          cmd_o.init = 1'b1;
          state_d    = StIssue;
        end
      end
      StIssue: begin
        cmd_o.issue = 1'b1;
        state_d     = StEval;
      end
      StEval: begin
        if (!sts_i.term) begin
          cmd_o.step = 1'b1;
          state_d    = StIssue;
        end else if (sts_i.need_second) begin
          cmd_o.keep_first = 1'b1;
          state_d          = StInit;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

[hw/rtl/mtsl_dp.sv]
// Datapath: list memories, counts, k-th selection registers and result registers.
module mtsl_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  mtsl_pkg::cmd_t                         cmd_i,
  input  logic signed [mtsl_pkg::ValW-1:0]       value_i,
  output mtsl_pkg::sts_t                         sts_o,
  output logic                                   done_o,
  output logic signed [mtsl_pkg::ResW-1:0]       twice_median_o,
  output logic                                   empty_res_o,
  output logic                                   overflow_o
);

  localparam int unsigned IdxW = mtsl_pkg::IdxW;
  localparam int unsigned ValW = mtsl_pkg::ValW;
  localparam int unsigned ResW = mtsl_pkg::ResW;

  typedef enum logic [1:0] {
    MODE_STEP,
    MODE_TERM_A,
    MODE_TERM_B,
    MODE_TERM_MIN
  } mode_e;

  logic signed [ValW-1:0] mem_a [mtsl_pkg::DepthA];
  logic signed [ValW-1:0] mem_b [mtsl_pkg::DepthB];

  logic [mtsl_pkg::CntAW-1:0] cnt_a_q;
  logic [mtsl_pkg::CntBW-1:0] cnt_b_q;
  logic                       dropped_q;
  logic                       full_a, full_b;

  logic signed [IdxW-1:0] m_q, n_q;
  logic signed [IdxW-1:0] sa_q, ea_q, sb_q, eb_q, k_q, ma_q, mb_q;
  logic                   pass_q;
  mode_e                  mode_q, mode_d;
  logic signed [ValW-1:0] rd_a_q, rd_b_q, first_q, res_val;

  logic signed [IdxW-1:0] tot, half, ma, mb, idx_a, idx_b, ha, hb;
  logic                   odd;

  assign full_a = (cnt_a_q == mtsl_pkg::CntAW'(mtsl_pkg::DepthA));
  assign full_b = (cnt_b_q == mtsl_pkg::CntBW'(mtsl_pkg::DepthB));

  assign tot  = m_q + n_q;
  assign half = tot >>> 1;
  assign odd  = tot[0];

  assign ma = (sa_q + ea_q) >>> 1;
  assign mb = (sb_q + eb_q) >>> 1;

  always_comb begin
    mode_d = MODE_STEP;
    idx_a  = ma;
    idx_b  = mb;
    if (ea_q < sa_q) begin
      mode_d = MODE_TERM_B;
      idx_b  = sb_q + k_q - IdxW'(1);
    end else if (eb_q < sb_q) begin
      mode_d = MODE_TERM_A;
      idx_a  = sa_q + k_q - IdxW'(1);
    end else if (k_q == IdxW'(1)) begin
      mode_d = MODE_TERM_MIN;
      idx_a  = sa_q;
      idx_b  = sb_q;
    end
  end

  always_comb begin
    case (mode_q)
      MODE_TERM_A:   res_val = rd_a_q;
      MODE_TERM_B:   res_val = rd_b_q;
      MODE_TERM_MIN: res_val = (rd_a_q <= rd_b_q) ? rd_a_q : rd_b_q;
      default:       res_val = rd_a_q;
    endcase
  end

  assign ha = ma_q - sa_q + IdxW'(1);
  assign hb = mb_q - sb_q + IdxW'(1);

  assign sts_o.empty       = (tot == '0);
  assign sts_o.term        = (mode_q != MODE_STEP);
  assign sts_o.need_second = !odd && !pass_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && !full_a) begin
      mem_a[cnt_a_q[mtsl_pkg::AddrAW-1:0]] <= value_i;
    end
    if (cmd_i.load_b && !full_b) begin
      mem_b[cnt_b_q[mtsl_pkg::AddrBW-1:0]] <= value_i;
    end
    if (cmd_i.issue) begin
      rd_a_q <= mem_a[idx_a[mtsl_pkg::AddrAW-1:0]];
      rd_b_q <= mem_b[idx_b[mtsl_pkg::AddrBW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      m_q <= $signed(IdxW'(cnt_a_q));
      n_q <= $signed(IdxW'(cnt_b_q));
    end
    if (cmd_i.init) begin
      sa_q <= '0;
      sb_q <= '0;
      ea_q <= m_q - IdxW'(1);
      eb_q <= n_q - IdxW'(1);
      k_q  <= pass_q ? half + IdxW'(1) : half + IdxW'(odd);
    end
    if (cmd_i.issue) begin
      mode_q <= mode_d;
      ma_q   <= ma;
      mb_q   <= mb;
    end
    if (cmd_i.step) begin
      if (rd_a_q >= rd_b_q) begin
        if (ha + hb > k_q) begin
          ea_q <= ma_q - IdxW'(1);
        end else begin
          sb_q <= mb_q + IdxW'(1);
          k_q  <= k_q - hb;
        end
      end else begin
        if (ha + hb > k_q) begin
          eb_q <= mb_q - IdxW'(1);
        end else begin
          sa_q <= ma_q + IdxW'(1);
          k_q  <= k_q - ha;
        end
      end
    end
    if (cmd_i.keep_first) begin
      first_q <= res_val;
    end
    if (cmd_i.finish) begin
      twice_median_o <= pass_q
                      ? $signed({first_q[ValW-1], first_q}) + $signed({res_val[ValW-1], res_val})
                      : $signed({res_val[ValW-1], res_val}) + $signed({res_val[ValW-1], res_val});
      empty_res_o    <= 1'b0;
      overflow_o     <= dropped_q;
    end else if (cmd_i.finish_empty) begin
      twice_median_o <= '0;
      empty_res_o    <= 1'b1;
      overflow_o     <= dropped_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      dropped_q <= 1'b0;
      pass_q    <= 1'b0;
      done_o    <= 1'b0;
    end else begin
      done_o <= cmd_i.finish || cmd_i.finish_empty;
      if (cmd_i.load_a) begin
        if (full_a) begin
          dropped_q <= 1'b1;
        end else begin
          cnt_a_q <= cnt_a_q + mtsl_pkg::CntAW'(1);
        end
      end
      if (cmd_i.load_b) begin
        if (full_b) begin
          dropped_q <= 1'b1;
        end else begin
          cnt_b_q <= cnt_b_q + mtsl_pkg::CntBW'(1);
        end
      end
      if (cmd_i.capture) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
        pass_q  <= 1'b0;
      end
      if (cmd_i.keep_first) begin
        pass_q <= 1'b1;
      end
    end
  end

endmodule

[hw/rtl/median_of_two_sorted_lists.sv]
// Top level: median of two ascending lists of signed 32-bit values.
//
// A transaction is accepted at a rising edge with start high and busy low.
// func_i selects: append value_i to list A, append to list B, or compute.
// Appends never raise busy; a full list drops the element and sets the
// sticky overflow flag.
// A compute transaction raises busy while a controller steps a k-th-smallest
// search over the two list memories: each halving step is a memory read
// state and a compare-and-update state, about log2 of the list lengths steps
// per pass, plus an init state and a final read per pass. An even
// total needs two passes. Both lists empty ends the compute from the init
// state, with no search.
// The result appears for one cycle with done_o high, in the cycle busy falls;
// twice_median_o holds twice the median, empty_res_o flags empty lists and
// overflow_o reports any dropped element. Compute clears both list counts.
// The receiver cannot stall; a result not taken in its cycle is lost.
// Reset clears the counts, the overflow flag and the controller; list
// contents are not cleared and need no clearing pass.
module median_of_two_sorted_lists (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             func_i,
  input  logic signed [mtsl_pkg::ValW-1:0]       value_i,
  output logic                                   done_o,
  output logic signed [mtsl_pkg::ResW-1:0]       twice_median_o,
  output logic                                   empty_res_o,
  output logic                                   overflow_o
);

  mtsl_pkg::cmd_t cmd;
  mtsl_pkg::sts_t sts;

  mtsl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  mtsl_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .value_i        (value_i),
    .sts_o          (sts),
    .done_o         (done_o),
    .twice_median_o (twice_median_o),
    .empty_res_o    (empty_res_o),
    .overflow_o     (overflow_o)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the median block: list loads, median computes, overflow drops.
`timescale 1ns / 100ps

module tb_top;
  import mtsl_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam longint ValMin = -64'sd2147483648;
  localparam longint ValMax = 64'sd2147483647;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 100;

  typedef struct {
    logic [1:0]               func;
    logic signed [ValW-1:0]   value;
    bit                       hold;
  } list_op_t;

  typedef struct {
    logic signed [ResW-1:0] twice;
    logic                   empty;
    logic                   ovf;
  } median_res_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             func_i = FuncAppendA;
  logic signed [ValW-1:0] value_i = '0;
  logic                   done_o;
  logic signed [ResW-1:0] twice_median_o;
  logic                   empty_res_o;
  logic                   overflow_o;

  list_op_t    op_q[$];
  median_res_t median_q[$];

  logic signed [ValW-1:0] lst_a [DepthA];
  logic signed [ValW-1:0] lst_b [DepthB];
  int cnt_a = 0;
  int cnt_b = 0;
  bit dropped = 1'b0;

  int n_items = 0;
  int n_accepted = 0;
  int n_issued = 0;
  int n_seen = 0;
  int err_cnt = 0;
  int stall_cyc = 0;

  median_of_two_sorted_lists DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .twice_median_o (twice_median_o),
    .empty_res_o    (empty_res_o),
    .overflow_o     (overflow_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic longint elem_a(int i);
    if (i < 0 || i >= DepthA) return 0;
    return lst_a[i];
  endfunction

  function automatic longint elem_b(int i);
    if (i < 0 || i >= DepthB) return 0;
    return lst_b[i];
  endfunction

  function automatic longint kth_smallest(int m, int n, int k);
    int sa, ea, sb, eb, ma, mb, ha, hb;
    sa = 0;
    ea = m - 1;
    sb = 0;
    eb = n - 1;
    while (1) begin
      if (ea < sa) return elem_b(sb + k - 1);
      if (eb < sb) return elem_a(sa + k - 1);
      if (k == 1) return (elem_a(sa) <= elem_b(sb)) ? elem_a(sa) : elem_b(sb);
      ma = (sa + ea) / 2;
      mb = (sb + eb) / 2;
      ha = ma - sa + 1;
      hb = mb - sb + 1;
      if (elem_a(ma) >= elem_b(mb)) begin
        if (ha + hb > k) ea = ma - 1;
        else begin
          sb = mb + 1;
          k -= hb;
        end
      end else begin
        if (ha + hb > k) eb = mb - 1;
        else begin
          sa = ma + 1;
          k -= ha;
        end
      end
    end
  endfunction

  task automatic apply_item(input logic [1:0] f, input logic signed [ValW-1:0] v);
    median_res_t res;
    longint tw;
    int tot;
    case (f)
      FuncAppendA: begin
        if (cnt_a < DepthA) begin
          lst_a[cnt_a] = v;
          cnt_a++;
        end else dropped = 1'b1;
      end
      FuncAppendB: begin
        if (cnt_b < DepthB) begin
          lst_b[cnt_b] = v;
          cnt_b++;
        end else dropped = 1'b1;
      end
      FuncMedian: begin
        tot = cnt_a + cnt_b;
        tw = 0;
        if (tot % 2) tw = 2 * kth_smallest(cnt_a, cnt_b, (tot + 1) / 2);
        else if (tot != 0) begin
          tw = kth_smallest(cnt_a, cnt_b, tot / 2) + kth_smallest(cnt_a, cnt_b, tot / 2 + 1);
        end
        res.twice = tw[ResW-1:0];
        res.empty = (tot == 0);
        res.ovf = dropped;
        median_q.push_back(res);
        cnt_a = 0;
        cnt_b = 0;
      end
      default: ;
    endcase
  endtask

  task automatic add_op(input logic [1:0] f, input logic [ValW-1:0] v, input bit hold);
    list_op_t op;
    op.func = f;
    op.value = v;
    op.hold = hold;
    op_q.push_back(op);
    if (f != FuncUnused) n_items++;
  endtask

  task automatic median_case(input int na, input int nb, input bit ordered, input bit hold);
    logic signed [ValW-1:0] qa[$];
    logic signed [ValW-1:0] qb[$];
    logic signed [ValW-1:0] v;
    longint cur;
    int unsigned step_max;
    int l, i, len, off;
    for (l = 0; l < 2; l++) begin
      len = (l == 0) ? na : nb;
      case ($urandom_range(0, 3))
        0: begin
          cur = longint'(signed'($urandom));
          step_max = 32'h0800_0000;
        end
        1: begin
          off = $urandom_range(0, 40);
          cur = off - 20;
          step_max = 3;
        end
        2: begin
          off = $urandom_range(0, 4);
          cur = ValMin + off;
          step_max = 2;
        end
        default: begin
          off = $urandom_range(0, 30);
          cur = ValMax - off;
          step_max = 4;
        end
      endcase
      for (i = 0; i < len; i++) begin
        v = (cur > ValMax) ? ValMax[ValW-1:0] : cur[ValW-1:0];
        if (!ordered) v = $urandom;
        if (l == 0) qa.push_back(v);
        else qb.push_back(v);
        cur += $urandom_range(0, step_max);
      end
    end
    while (qa.size() + qb.size() > 0) begin
      if ($urandom_range(0, 19) == 0) add_op(FuncUnused, $urandom, 1'b0);
      if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 1)) begin
        add_op(FuncAppendA, qa.pop_front(), 1'b0);
      end else begin
        add_op(FuncAppendB, qb.pop_front(), 1'b0);
      end
    end
    add_op(FuncMedian, $urandom, hold);
  endtask

  task automatic random_case();
    int na, nb;
    na = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
    nb = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
    median_case(na, nb, $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    list_op_t nxt;
    bit took;
    bit quiet;
    int owed;
    if (!rst_ni) begin
      start <= 1'b0;
      func_i <= FuncAppendA;
      value_i <= '0;
    end else begin
      took = start && !busy;
      if (took) begin
        apply_item(func_i, value_i);
        n_accepted <= n_accepted + 1;
        if (func_i == FuncMedian) n_issued <= n_issued + 1;
      end
      if (!start || took) begin
        owed = n_issued - n_seen + ((took && func_i == FuncMedian) ? 1 : 0);
        quiet = (n_accepted >= 200 && n_accepted < 400);
        if (op_q.size() != 0 && !(op_q[0].hold && owed != 0) &&
            (quiet || $urandom_range(0, 99) >= 37)) begin
          nxt = op_q.pop_front();
          start <= 1'b1;
          func_i <= nxt.func;
          value_i <= nxt.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    median_res_t want;
    if (rst_ni && done_o) begin
      n_seen <= n_seen + 1;
      if (median_q.size() == 0) begin
        report_mismatch("result with no transaction pending", twice_median_o, 0);
      end else begin
        want = median_q.pop_front();
        if (twice_median_o !== want.twice) begin
          report_mismatch("twice_median", twice_median_o, want.twice);
        end
        if (empty_res_o !== want.empty) report_mismatch("empty_res", empty_res_o, want.empty);
        if (overflow_o !== want.ovf) report_mismatch("overflow", overflow_o, want.ovf);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cyc <= 0;
      end else if (stall_cyc >= StallLimit) begin
        $display("Watchdog: no transaction for %0d cycles", StallLimit);
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cyc <= stall_cyc + 1;
      end
    end
  end

  initial begin
    add_op(FuncMedian, '0, 1'b0);
    add_op(FuncUnused, 32'hFFFF_FFFF, 1'b0);
    add_op(FuncAppendA, 32'h8000_0000, 1'b0);
    add_op(FuncAppendA, 32'h7FFF_FFFF, 1'b0);
    add_op(FuncAppendB, 32'h0000_0000, 1'b0);
    add_op(FuncMedian, '0, 1'b0);
    add_op(FuncAppendA, 32'hFFFF_FFFF, 1'b0);
    add_op(FuncMedian, 32'hFFFF_FFFF, 1'b0);
    add_op(FuncAppendB, 32'h5555_5555, 1'b0);
    add_op(FuncMedian, 32'hAAAA_AAAA, 1'b0);
    add_op(FuncAppendB, 32'h7FFF_FFFF, 1'b0);
    add_op(FuncAppendB, 32'h7FFF_FFFF, 1'b0);
    add_op(FuncMedian, '0, 1'b0);
    add_op(FuncAppendA, 32'h8000_0000, 1'b0);
    add_op(FuncAppendB, 32'h8000_0000, 1'b0);
    add_op(FuncMedian, '0, 1'b0);
    add_op(FuncAppendA, 32'd5, 1'b0);
    add_op(FuncAppendA, -32'sd3, 1'b0);
    add_op(FuncAppendA, 32'd7, 1'b0);
    add_op(FuncAppendB, 32'd2, 1'b0);
    add_op(FuncAppendB, -32'sd9, 1'b0);
    add_op(FuncMedian, '0, 1'b1);
    while (n_items < 580) random_case();
    median_case(258, 258, 1'b1, 1'b1);
    repeat (6) random_case();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i); while (op_q.size() != 0 || start || n_issued != n_seen);
    repeat (DrainCycles) @(negedge clk_i);
    if (median_q.size() != 0) report_mismatch("results never seen", median_q.size(), 0);
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mtsl_pkg.sv
hw/rtl/mtsl_ctrl.sv
hw/rtl/mtsl_dp.sv
hw/rtl/median_of_two_sorted_lists.sv
tb/tb_top.sv
